@@ design/ordered_array_list_engine_defines.svh @@
// ---------------------------------------------------------------------------
// ordered array list engine: assertion macros
// shared assertion forms, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define OAL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oal assertion failed");

// next-cycle implication
`define OAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oal assertion failed");

`endif

@@ design/oal_pkg.sv @@
// ---------------------------------------------------------------------------
// oal_pkg
// types and constants of the ordered array list engine
// ---------------------------------------------------------------------------
package oal_pkg;

  localparam int DEPTH  = 32;
  localparam int IdxW   = $clog2(DEPTH);
  localparam int CntW   = 6;
  localparam int PosW   = 6;
  localparam int CmdW   = 3;
  localparam int DataW  = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  item_value;
  } in_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0]  result_value;
    logic [PosW-1:0]          found_position;
    logic [CntW-1:0]          entry_count;
    logic                     is_empty;
    logic                     is_full;
  } out_word_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic                     shift_en;
    logic                     insert;
    logic [IdxW-1:0]          pos_idx;
    logic signed [DataW-1:0]  value;
    logic [CntW-1:0]          count;
  } cell_ctrl_t;

endpackage

@@ design/oal_if.sv @@
// ---------------------------------------------------------------------------
// oal stream interfaces
// valid/ready channels for command words and result words
// ---------------------------------------------------------------------------
interface oal_in_if;
  import oal_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oal_out_if;
  import oal_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/oal_cell.sv @@
// ---------------------------------------------------------------------------
// oal_cell
// one list entry: shifts with its neighbors and compares against the key
// ---------------------------------------------------------------------------
module oal_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [oal_pkg::IdxW-1:0]        idx_i,
  input  oal_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [oal_pkg::DataW-1:0] left_i,
  input  logic signed [oal_pkg::DataW-1:0] right_i,
  output logic signed [oal_pkg::DataW-1:0] entry_o,
  output logic                            match_o
);
  import oal_pkg::*;

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    match_q;
  logic                    live;

  assign live = CntW'(idx_i) < ctrl_i.count;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en) begin
      if (ctrl_i.insert) begin
        if (idx_i == ctrl_i.pos_idx) begin
          entry_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.pos_idx) begin
          entry_d = left_i;
        end
      end else if (idx_i >= ctrl_i.pos_idx) begin
        entry_d = right_i;
      end
    end
  end

  // entry is payload, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= live && (entry_q == ctrl_i.value);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ design/ordered_array_list_engine.sv @@
// ---------------------------------------------------------------------------
// ordered_array_list_engine
// ordered list of signed 32-bit words with insert, delete, find, read, clear
// ---------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one entry each; insert moves every
// cell past the position one step right, delete one step left, all in the
// same cycle. Each command word goes through accept, execute in the cell row
// (shift, per-cell compare, entry read), then result build, where a priority
// encoder turns the registered match bits into the first position.
// One command is in flight at a time; the result register lets the next
// command be taken while the last result still waits on out_o. A stalled
// result holds the engine in its result cycle until out_o takes it.
// ---------------------------------------------------------------------------
`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  oal_in_if.sink    in_i,
  oal_out_if.source out_o
);
  import oal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e                  state_q;
  logic [CmdW-1:0]         cmd_q;
  logic [PosW-1:0]         pos_q;
  logic signed [DataW-1:0] val_q;
  logic [CntW-1:0]         count_q;
  logic                    ok_q;
  logic signed [DataW-1:0] rd_q;
  logic                    out_valid_q;
  out_word_t               out_q;

  // command checks against the current count
  logic       ins_ok, pos_ok, del_go, ins_go;
  logic [IdxW-1:0] pos_idx;
  cell_ctrl_t cell_ctrl;

  assign ins_ok  = (count_q < CntW'(DEPTH)) && (pos_q != '0)
                && (pos_q <= (count_q + CntW'(1)));
  assign pos_ok  = (pos_q != '0) && (pos_q <= count_q);
  assign ins_go  = (cmd_q == CMD_INSERT) && ins_ok;
  assign del_go  = (cmd_q == CMD_DELETE) && pos_ok;
  assign pos_idx = IdxW'(pos_q - PosW'(1));

  always_comb begin
    cell_ctrl.shift_en = (state_q == S_EXEC) && (ins_go || del_go);
    cell_ctrl.insert   = (cmd_q == CMD_INSERT);
    cell_ctrl.pos_idx  = pos_idx;
    cell_ctrl.value    = val_q;
    cell_ctrl.count    = count_q;
  end

  // row of cells, neighbors chained, zero fed in at both ends
  logic signed [DataW-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]        match_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    oal_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IdxW'(i)),
      .ctrl_i  (cell_ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .match_o (match_w[i])
    );
  end

  // first match, lowest index wins
  logic            any_match;
  logic [PosW-1:0] first_pos;

  always_comb begin
    any_match = |match_w;
    first_pos = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match_w[k]) begin
        first_pos = PosW'(k + 1);
      end
    end
  end

  // result word built in the response cycle
  out_word_t resp_w;
  logic      is_find, is_fetch;

  assign is_find  = (cmd_q == CMD_FIND);
  assign is_fetch = (cmd_q == CMD_DELETE) || (cmd_q == CMD_READ);

  always_comb begin
    resp_w.ok             = is_find ? any_match : ok_q;
    resp_w.result_value   = (is_fetch && ok_q) ? rd_q : '0;
    resp_w.found_position = (is_find && any_match) ? first_pos : '0;
    resp_w.entry_count    = count_q;
    resp_w.is_empty       = (count_q == '0);
    resp_w.is_full        = (count_q == CntW'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      ok_q        <= 1'b0;
      rd_q        <= '0;
      out_q       <= '0;
    end else begin
      // drained word, unless the result cycle refills the register
      if (out_valid_q && out_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q   <= in_i.payload.cmd;
            pos_q   <= in_i.payload.position;
            val_q   <= in_i.payload.item_value;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          // entry read before the row shifts
          rd_q <= entry_w[pos_idx];
          unique case (cmd_q)
            CMD_INSERT: begin
              ok_q <= ins_ok;
              if (ins_ok) begin
                count_q <= count_q + CntW'(1);
              end
            end
            CMD_DELETE: begin
              ok_q <= pos_ok;
              if (pos_ok) begin
                count_q <= count_q - CntW'(1);
              end
            end
            CMD_READ:  ok_q <= pos_ok;
            CMD_CLEAR: begin
              ok_q    <= 1'b1;
              count_q <= '0;
            end
            default:   ok_q <= 1'b0;
          endcase
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= resp_w;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // checks
  logic ins_exec, flags_ok;

  assign ins_exec = (state_q == S_EXEC) && ins_go;
  assign flags_ok = (out_q.is_empty == (out_q.entry_count == '0))
                 && (out_q.is_full == (out_q.entry_count == CntW'(DEPTH)));

  `OAL_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(DEPTH))
  `OAL_ASSERT_NEXT(a_count_only_exec, state_q != S_EXEC, count_q == $past(count_q))
  `OAL_ASSERT_NEXT(a_insert_grows, ins_exec, count_q == $past(count_q) + CntW'(1))
  `OAL_ASSERT_IMPL(a_out_flags, out_valid_q, flags_ok)

endmodule
